>>> rtl/rosat_pkg.sv
package rosat_pkg;

  // Queue between the front and the back part
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Corner store geometry: two rectangles of four corners each
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned ADDR_BITS   = $clog2(STORE_DEPTH);

  // Classification of one queued transaction
  typedef struct packed {
    logic                 run_test;
    logic [ADDR_BITS-1:0] addr;
  } rosat_tag_t;

  // Sequencer of the overlap test
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_NORM,
    ST_PROJ_RD,
    ST_PROJ_MUL,
    ST_PROJ_SUM,
    ST_CHECK
  } rosat_state_t;

endpackage

>>> rtl/rosat_front.sv
module rosat_front #(
  parameter int COORD_BITS = 15
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    shape_select,
  input  logic [1:0]              corner_index,
  input  logic [COORD_BITS-1:0]   x_coord,
  input  logic [COORD_BITS-1:0]   y_coord,
  input  logic                    last,
  output logic                    q_valid,
  output rosat_pkg::rosat_tag_t   q_tag,
  output logic [COORD_BITS-1:0]   q_x,
  output logic [COORD_BITS-1:0]   q_y,
  input  logic                    q_pop
);

  rosat_pkg::rosat_tag_t tag_q [rosat_pkg::QUEUE_DEPTH];
  logic [COORD_BITS-1:0] x_q   [rosat_pkg::QUEUE_DEPTH];
  logic [COORD_BITS-1:0] y_q   [rosat_pkg::QUEUE_DEPTH];

  logic [rosat_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [rosat_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [rosat_pkg::QPTR_BITS:0]   count;
  logic                            push;
  logic                            pop;
  rosat_pkg::rosat_tag_t           in_tag;

  // Classify the incoming corner: store address and whether it runs the test
  always_comb begin
    in_tag.run_test = last;
    in_tag.addr     = {shape_select, corner_index};
  end

  assign busy    = (count == (rosat_pkg::QPTR_BITS+1)'(rosat_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign pop     = q_pop && q_valid;

  assign q_tag = tag_q[rd_ptr];
  assign q_x   = x_q[rd_ptr];
  assign q_y   = y_q[rd_ptr];

  // Hold queued transactions
  always_ff @(posedge clk) begin
    if (push) begin
      tag_q[wr_ptr] <= in_tag;
      x_q[wr_ptr]   <= x_coord;
      y_q[wr_ptr]   <= y_coord;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/rosat_back.sv
module rosat_back #(
  parameter int COORD_BITS = 15
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  rosat_pkg::rosat_tag_t   q_tag,
  input  logic [COORD_BITS-1:0]   q_x,
  input  logic [COORD_BITS-1:0]   q_y,
  output logic                    q_pop,
  output logic                    done,
  output logic                    collides
);

  localparam int NW = COORD_BITS + 1;     // edge normal
  localparam int MW = 2 * COORD_BITS + 1; // one product
  localparam int PW = 2 * COORD_BITS + 2; // dot product

  rosat_pkg::rosat_state_t state;
  rosat_pkg::rosat_state_t state_next;

  // Corner store: y in the high half, x in the low half
  logic [2*COORD_BITS-1:0] mem [rosat_pkg::STORE_DEPTH];
  logic [2*COORD_BITS-1:0] rd_data;
  logic [rosat_pkg::ADDR_BITS-1:0] raddr;

  logic [1:0]                      axis;
  logic [rosat_pkg::ADDR_BITS-1:0] k;
  logic signed [COORD_BITS-1:0]    a_x;
  logic signed [COORD_BITS-1:0]    a_y;
  logic signed [NW-1:0]            norm_x;
  logic signed [NW-1:0]            norm_y;
  logic signed [MW-1:0]            prod_x;
  logic signed [MW-1:0]            prod_y;
  logic signed [PW-1:0]            proj;
  logic signed [PW-1:0]            lo0;
  logic signed [PW-1:0]            hi0;
  logic signed [PW-1:0]            lo1;
  logic signed [PW-1:0]            hi1;
  logic signed [COORD_BITS-1:0]    rd_x;
  logic signed [COORD_BITS-1:0]    rd_y;
  logic                            ovl;

  assign rd_x = rd_data[COORD_BITS-1:0];
  assign rd_y = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign proj = PW'(prod_x) + PW'(prod_y);
  assign ovl  = ((lo0 <= lo1) && (lo1 <= hi0)) || ((lo1 <= lo0) && (lo0 <= hi1));

  // Next state, pop and read address
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    raddr      = k;
    case (state)
      rosat_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_tag.run_test) begin
            state_next = rosat_pkg::ST_EDGE_A;
          end
        end
      end
      rosat_pkg::ST_EDGE_A: begin
        raddr      = {axis[1], 1'b0, axis[0]};
        state_next = rosat_pkg::ST_EDGE_B;
      end
      rosat_pkg::ST_EDGE_B: begin
        raddr      = {axis[1], (axis[0] ? 2'd2 : 2'd1)};
        state_next = rosat_pkg::ST_NORM;
      end
      rosat_pkg::ST_NORM: begin
        state_next = rosat_pkg::ST_PROJ_RD;
      end
      rosat_pkg::ST_PROJ_RD: begin
        state_next = rosat_pkg::ST_PROJ_MUL;
      end
      rosat_pkg::ST_PROJ_MUL: begin
        state_next = rosat_pkg::ST_PROJ_SUM;
      end
      rosat_pkg::ST_PROJ_SUM: begin
        if (k == '1) begin
          state_next = rosat_pkg::ST_CHECK;
        end else begin
          state_next = rosat_pkg::ST_PROJ_RD;
        end
      end
      rosat_pkg::ST_CHECK: begin
        if (!ovl || (axis == 2'd3)) begin
          state_next = rosat_pkg::ST_IDLE;
        end else begin
          state_next = rosat_pkg::ST_EDGE_A;
        end
      end
      default: begin
        state_next = rosat_pkg::ST_IDLE;
      end
    endcase
  end

  // Write corners from the queue, read one entry a cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem[q_tag.addr] <= {q_y, q_x};
    end
    rd_data <= mem[raddr];
  end

  // Control state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rosat_pkg::ST_IDLE;
      axis  <= '0;
      k     <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == rosat_pkg::ST_CHECK) && (!ovl || (axis == 2'd3));
      case (state)
        rosat_pkg::ST_IDLE: begin
          axis <= '0;
          k    <= '0;
        end
        rosat_pkg::ST_NORM: begin
          k <= '0;
        end
        rosat_pkg::ST_PROJ_SUM: begin
          k <= k + 1'b1;
        end
        rosat_pkg::ST_CHECK: begin
          axis <= axis + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath: edge normal, products, projection range
  always_ff @(posedge clk) begin
    collides <= ovl;
    case (state)
      rosat_pkg::ST_EDGE_B: begin
        a_x <= rd_x;
        a_y <= rd_y;
      end
      rosat_pkg::ST_NORM: begin
        norm_x <= NW'(rd_y) - NW'(a_y);
        norm_y <= NW'(a_x) - NW'(rd_x);
      end
      rosat_pkg::ST_PROJ_MUL: begin
        prod_x <= MW'(rd_x) * MW'(norm_x);
        prod_y <= MW'(rd_y) * MW'(norm_y);
      end
      rosat_pkg::ST_PROJ_SUM: begin
        if (!k[2]) begin
          if ((k[1:0] == 2'd0) || (proj < lo0)) lo0 <= proj;
          if ((k[1:0] == 2'd0) || (proj > hi0)) hi0 <= proj;
        end else begin
          if ((k[1:0] == 2'd0) || (proj < lo1)) lo1 <= proj;
          if ((k[1:0] == 2'd0) || (proj > hi1)) hi1 <= proj;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/rectangle_overlap_sat_unit.sv
// Channel  | Handshake     | Payload
// ---------+---------------+--------------------------------------------------
// corner   | start / busy  | shape_select, corner_index, x_coord, y_coord, last
// result   | done (strobe) | collides
//
// A corner is taken when start is high and busy is low; busy rises only when
// the two-entry queue is full. While no test runs, a corner leaves the queue
// and reaches the store at the edge after it is taken. A corner with last runs
// the test on one store read port and two multipliers over up to four axes:
// for each axis it reads two corners, forms the edge normal, projects all eight
// corners and stops at a separating axis. done lasts one cycle and cannot be
// stalled. Synchronous reset empties the queue and idles the test.
module rectangle_overlap_sat_unit #(
  parameter int COORD_BITS = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  shape_select,
  input  logic [1:0]            corner_index,
  input  logic [COORD_BITS-1:0] x_coord,
  input  logic [COORD_BITS-1:0] y_coord,
  input  logic                  last,
  output logic                  done,
  output logic                  collides
);

  logic                  q_valid;
  logic                  q_pop;
  rosat_pkg::rosat_tag_t q_tag;
  logic [COORD_BITS-1:0] q_x;
  logic [COORD_BITS-1:0] q_y;

  rosat_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .shape_select (shape_select),
    .corner_index (corner_index),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .last         (last),
    .q_valid      (q_valid),
    .q_tag        (q_tag),
    .q_x          (q_x),
    .q_y          (q_y),
    .q_pop        (q_pop)
  );

  rosat_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_tag    (q_tag),
    .q_x      (q_x),
    .q_y      (q_y),
    .q_pop    (q_pop),
    .done     (done),
    .collides (collides)
  );

endmodule
